// ===== design/fct_pkg.sv =====
package fct_pkg;

	localparam int PLANE_COUNT = 6;
	localparam int REG_COUNT = 6;
	localparam int LANES = (PLANE_COUNT < REG_COUNT) ? PLANE_COUNT : REG_COUNT;
	localparam int ADDR_W = 6;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] OP_POINT = 2'd0;
	localparam logic [1:0] OP_SPHERE = 2'd1;
	localparam logic [1:0] OP_BOX = 2'd2;
	localparam logic [1:0] OP_DIST = 2'd3;

	localparam logic [1:0] VERDICT_INSIDE = 2'd0;
	localparam logic [1:0] VERDICT_INTERSECT = 2'd1;
	localparam logic [1:0] VERDICT_OUTSIDE = 2'd2;

	typedef logic [63:0] plane_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic [14:0] radius;
		logic [14:0] half_x;
		logic [14:0] half_y;
		logic [14:0] half_z;
		logic [47:0] axis_u;
		logic [47:0] axis_v;
		logic [47:0] axis_w;
		logic [2:0] plane_select;
	} in_item_t;

	typedef struct packed {
		logic [1:0] verdict;
		logic signed [23:0] signed_distance;
	} result_t;

	typedef struct packed {
		logic is_sphere;
		logic is_box;
		logic is_dist;
		logic sel_ok;
	} cmd_flags_t;

	typedef struct packed {
		cmd_flags_t flags;
		in_item_t item;
	} cmd_t;

	function automatic logic signed [15:0] lane16(logic [63:0] v, int k);
		lane16 = v[16*k +: 16];
	endfunction

endpackage

// ===== design/fct_cfg.sv =====
module fct_cfg (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [fct_pkg::ADDR_W-1:0] paddr,
	input logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready,
	output fct_pkg::plane_t planes [fct_pkg::REG_COUNT]
);

	logic [2:0] idx;
	fct_pkg::plane_t plane_q [fct_pkg::REG_COUNT];

	assign idx = paddr[5:3];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fct_pkg::REG_COUNT; i++) plane_q[i] <= '0;
		end else if (psel && penable && pwrite) begin
			for (int i = 0; i < fct_pkg::REG_COUNT; i++) begin
				if (idx == 3'(i)) plane_q[i] <= pwdata;
			end
		end
	end

	always_comb begin
		prdata = '0;
		for (int i = 0; i < fct_pkg::REG_COUNT; i++) begin
			if (idx == 3'(i)) prdata = plane_q[i];
		end
	end

	assign planes = plane_q;

endmodule

// ===== design/fct_front.sv =====
module fct_front (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input fct_pkg::in_item_t in_item,
	output logic push,
	output fct_pkg::cmd_t cmd
);

	fct_pkg::cmd_flags_t flags;
	logic v_s1;
	fct_pkg::cmd_t cmd_s1;

	always_comb begin
		flags = '0;
		flags.sel_ok = in_item.plane_select < 3'(fct_pkg::LANES);
		unique case (in_item.opcode)
			fct_pkg::OP_POINT: ;
			fct_pkg::OP_SPHERE: flags.is_sphere = 1'b1;
			fct_pkg::OP_BOX: flags.is_box = 1'b1;
			fct_pkg::OP_DIST: flags.is_dist = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.flags <= flags;
			cmd_s1.item <= in_item;
		end
	end

	assign push = v_s1;
	assign cmd = cmd_s1;

endmodule

// ===== design/fct_queue.sv =====
module fct_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input fct_pkg::cmd_t push_cmd,
	output logic pop,
	output fct_pkg::cmd_t pop_cmd,
	output logic full
);

	fct_pkg::cmd_t mem_q [fct_pkg::QUEUE_DEPTH];
	logic wr_q;
	logic rd_q;
	logic [1:0] count_q;

	assign pop = count_q != 2'd0;
	assign full = count_q == 2'(fct_pkg::QUEUE_DEPTH);
	assign pop_cmd = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_cmd;
	end

endmodule

// ===== design/fct_back.sv =====
module fct_back (
	input logic clk,
	input logic arst_n,
	input logic valid,
	input fct_pkg::cmd_t cmd,
	input fct_pkg::plane_t planes [fct_pkg::REG_COUNT],
	output logic done,
	output fct_pkg::result_t result
);

	localparam int L = fct_pkg::LANES;

	logic v_s1, v_s2, v_s3, v_s4;
	fct_pkg::cmd_t c_s1, c_s2, c_s3;

	logic signed [31:0] dp_s1 [L][3];
	logic signed [15:0] off_s1 [L];
	logic signed [31:0] pp_s1 [L][3][3];

	logic signed [33:0] d22_s2 [L];
	logic [32:0] proj_s2 [L][3];

	logic signed [33:0] d22_s3 [L];
	logic [47:0] lp_s3 [L][3];

	logic [L-1:0] outside;
	logic [L-1:0] touch;
	logic signed [34:0] rnd;
	logic signed [33:0] dsel;
	fct_pkg::result_t res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		c_s1 <= cmd;
		c_s2 <= c_s1;
		c_s3 <= c_s2;
		for (int i = 0; i < L; i++) begin
			off_s1[i] <= fct_pkg::lane16(planes[i], 3);
			dp_s1[i][0] <= fct_pkg::lane16(planes[i], 0) * cmd.item.pos_x;
			dp_s1[i][1] <= fct_pkg::lane16(planes[i], 1) * cmd.item.pos_y;
			dp_s1[i][2] <= fct_pkg::lane16(planes[i], 2) * cmd.item.pos_z;
			for (int k = 0; k < 3; k++) begin
				pp_s1[i][0][k] <= fct_pkg::lane16({16'd0, cmd.item.axis_u}, k)
					* fct_pkg::lane16(planes[i], k);
				pp_s1[i][1][k] <= fct_pkg::lane16({16'd0, cmd.item.axis_v}, k)
					* fct_pkg::lane16(planes[i], k);
				pp_s1[i][2][k] <= fct_pkg::lane16({16'd0, cmd.item.axis_w}, k)
					* fct_pkg::lane16(planes[i], k);
			end
		end
		for (int i = 0; i < L; i++) begin
			d22_s2[i] <= (34'(off_s1[i]) <<< 14) + 34'(dp_s1[i][0])
				+ 34'(dp_s1[i][1]) + 34'(dp_s1[i][2]);
			for (int a = 0; a < 3; a++) begin
				logic signed [33:0] s;
				s = 34'(pp_s1[i][a][0]) + 34'(pp_s1[i][a][1]) + 34'(pp_s1[i][a][2]);
				proj_s2[i][a] <= s[33] ? 33'(-s) : s[32:0];
			end
		end
		for (int i = 0; i < L; i++) begin
			d22_s3[i] <= d22_s2[i];
			lp_s3[i][0] <= 48'(c_s2.item.half_x * proj_s2[i][0]);
			lp_s3[i][1] <= 48'(c_s2.item.half_y * proj_s2[i][1]);
			lp_s3[i][2] <= 48'(c_s2.item.half_z * proj_s2[i][2]);
		end
		result <= res_s4;
	end

	always_comb begin
		for (int i = 0; i < L; i++) begin
			logic [49:0] lim;
			logic signed [51:0] dl;
			logic signed [51:0] lm;
			lim = 50'(lp_s3[i][0]) + 50'(lp_s3[i][1]) + 50'(lp_s3[i][2]);
			dl = 52'(d22_s3[i]) <<< 14;
			if (c_s3.flags.is_sphere) lm = 52'(c_s3.item.radius) << 28;
			else if (c_s3.flags.is_box) lm = {2'b00, lim};
			else lm = '0;
			outside[i] = dl < -lm;
			touch[i] = !outside[i] && (c_s3.flags.is_sphere || c_s3.flags.is_box)
				&& (dl <= lm);
		end
		dsel = '0;
		for (int i = 0; i < L; i++) begin
			if (c_s3.item.plane_select == 3'(i)) dsel = d22_s3[i];
		end
		rnd = (35'(dsel) + 35'sd8192) >>> 14;
		res_s4 = '0;
		if (c_s3.flags.is_dist) begin
			if (c_s3.flags.sel_ok) res_s4.signed_distance = 24'(rnd);
		end else if (|outside) begin
			res_s4.verdict = fct_pkg::VERDICT_OUTSIDE;
		end else if (|touch) begin
			res_s4.verdict = fct_pkg::VERDICT_INTERSECT;
		end else begin
			res_s4.verdict = fct_pkg::VERDICT_INSIDE;
		end
	end

	assign done = v_s4;

endmodule

// ===== design/frustum_cull_tester_core.sv =====
// channel   | ports                                   | handshake
// request   | start, busy, in_item                    | taken when start && !busy
// result    | done, result                            | one-cycle strobe, no back-pressure
// config    | psel penable pwrite paddr pwdata prdata | APB write on access cycle
//
// One transaction per cycle; after the accepting edge, done strobes once the item has passed
// the front register, the queue, three stages of plane arithmetic and the output register.
// Six plane lanes work in parallel, so every plane is tested in the same pass.
// Reset clears planes to zero and empties the queue; busy stays low, as the back end
// drains the queue every cycle.
module frustum_cull_tester_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input fct_pkg::in_item_t in_item,
	output logic done,
	output fct_pkg::result_t result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [fct_pkg::ADDR_W-1:0] paddr,
	input logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);

	fct_pkg::plane_t planes [fct_pkg::REG_COUNT];
	logic push, pop, full;
	fct_pkg::cmd_t front_cmd, back_cmd;

	assign busy = full;

	fct_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .planes(planes)
	);

	fct_front u_front (
		.clk(clk), .arst_n(arst_n), .accept(start && !busy), .in_item(in_item),
		.push(push), .cmd(front_cmd)
	);

	fct_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_cmd(front_cmd),
		.pop(pop), .pop_cmd(back_cmd), .full(full)
	);

	fct_back u_back (
		.clk(clk), .arst_n(arst_n), .valid(pop), .cmd(back_cmd), .planes(planes),
		.done(done), .result(result)
	);

	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.verdict != 2'd3) else $error("bad verdict code");

	a_unused_dist: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.verdict != fct_pkg::VERDICT_INSIDE |-> result.signed_distance == '0)
		else $error("distance set on a test");

	a_pop_follows_push: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> $past(push) || $past(pop)) else $error("queue pop without entry");

endmodule

// ===== test/tb_top.sv =====
module tb_top;

	localparam int HOLD_CYCLES = 12;

	class cull_scoreboard;
		logic [63:0] planes [fct_pkg::REG_COUNT];
		fct_pkg::result_t pending [$];
		int mismatches;

		function new();
			foreach (planes[i]) planes[i] = '0;
			mismatches = 0;
		endfunction

		function longint sx(logic [63:0] v, int k);
			logic signed [15:0] s;
			s = v[16*k +: 16];
			return longint'(s);
		endfunction

		function longint plane_dist(int p, longint px, longint py, longint pz);
			return sx(planes[p], 3) * 16384 + sx(planes[p], 0) * px
				+ sx(planes[p], 1) * py + sx(planes[p], 2) * pz;
		endfunction

		function longint axis_proj(int p, logic [47:0] ax);
			longint s;
			s = sx(ax, 0) * sx(planes[p], 0) + sx(ax, 1) * sx(planes[p], 1)
				+ sx(ax, 2) * sx(planes[p], 2);
			return s < 0 ? -s : s;
		endfunction

		function void note_item(fct_pkg::in_item_t it);
			fct_pkg::result_t r;
			longint px, py, pz, d, lim, q;
			bit outside, touch;
			px = it.pos_x;
			py = it.pos_y;
			pz = it.pos_z;
			r = '0;
			outside = 0;
			touch = 0;
			if (it.opcode == fct_pkg::OP_DIST) begin
				if (it.plane_select < fct_pkg::LANES) begin
					q = (plane_dist(it.plane_select, px, py, pz) + 8192) >>> 14;
					if (q > 8388607) q = 8388607;
					if (q < -8388608) q = -8388608;
					r.signed_distance = q[23:0];
				end
			end else begin
				for (int i = 0; i < fct_pkg::LANES; i++) begin
					d = plane_dist(i, px, py, pz);
					if (it.opcode == fct_pkg::OP_POINT) lim = 0;
					else if (it.opcode == fct_pkg::OP_SPHERE) lim = longint'(it.radius) * 16384;
					else begin
						d = d * 16384;
						lim = longint'(it.half_x) * axis_proj(i, it.axis_u)
							+ longint'(it.half_y) * axis_proj(i, it.axis_v)
							+ longint'(it.half_z) * axis_proj(i, it.axis_w);
					end
					if (d < -lim) outside = 1;
					else if (it.opcode != fct_pkg::OP_POINT && d <= lim) touch = 1;
				end
				r.verdict = outside ? fct_pkg::VERDICT_OUTSIDE
					: (touch ? fct_pkg::VERDICT_INTERSECT : fct_pkg::VERDICT_INSIDE);
			end
			pending.push_back(r);
		endfunction

		function void check_result(fct_pkg::result_t got);
			fct_pkg::result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
				return;
			end
			want = pending.pop_front();
			if (got.verdict !== want.verdict || got.signed_distance !== want.signed_distance) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected verdict %0d dist %0d, got verdict %0d dist %0d",
						want.verdict, want.signed_distance, got.verdict, got.signed_distance);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	fct_pkg::in_item_t in_item = '0;
	logic done;
	fct_pkg::result_t result;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [fct_pkg::ADDR_W-1:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;
	cull_scoreboard sb = new();

	frustum_cull_tester_core dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (done) sb.check_result(result);
		if (start && !busy) sb.note_item(in_item);
	end

	task automatic write_plane(int idx, logic [63:0] val);
		@(negedge clk);
		psel <= 1; pwrite <= 1; paddr <= fct_pkg::ADDR_W'(8 * idx); pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (idx < fct_pkg::REG_COUNT) sb.planes[idx] = val;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (HOLD_CYCLES) @(negedge clk);
	endtask

	task automatic send(fct_pkg::in_item_t it);
		start <= 1;
		in_item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic pause_random();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) != 0) n = 0;
		if (n > 0) begin
			start <= 0;
			repeat (n) @(negedge clk);
		end
	endtask

	function automatic logic [15:0] unit_lane();
		case ($urandom_range(0, 4))
			0: return 16'h4000;
			1: return 16'hC000;
			2: return 16'h0000;
			3: return 16'($urandom_range(0, 32767) - 16384);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [63:0] rand_plane(int mode);
		logic [15:0] off;
		case (mode)
			0: return {$urandom, $urandom};
			1: return {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
			2: return {16'h8000, 16'h8000, 16'h8000, 16'h8000};
			default: begin
				off = 16'($urandom_range(0, 8191) - 4096);
				return {off, unit_lane(), unit_lane(), unit_lane()};
			end
		endcase
	endfunction

	function automatic fct_pkg::in_item_t rand_item();
		fct_pkg::in_item_t it;
		logic [319:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom};
		it = raw[$bits(fct_pkg::in_item_t)-1:0];
		if ($urandom_range(0, 1)) begin
			it.pos_x = 16'($urandom_range(0, 4095) - 2048);
			it.pos_y = 16'($urandom_range(0, 4095) - 2048);
			it.pos_z = 16'($urandom_range(0, 4095) - 2048);
			it.radius = 15'($urandom_range(0, 2047));
			it.half_x = 15'($urandom_range(0, 1023));
			it.half_y = 15'($urandom_range(0, 1023));
			it.half_z = 15'($urandom_range(0, 1023));
			it.axis_u = {unit_lane(), unit_lane(), unit_lane()};
			it.axis_v = {unit_lane(), unit_lane(), unit_lane()};
			it.axis_w = {unit_lane(), unit_lane(), unit_lane()};
		end
		if ($urandom_range(0, 3) != 0) it.plane_select = 3'($urandom_range(0, 5));
		return it;
	endfunction

	task automatic directed();
		fct_pkg::in_item_t it;
		for (int op = 0; op < 4; op++) begin
			for (int k = 0; k < 5; k++) begin
				it = '0;
				it.opcode = 2'(op);
				it.plane_select = 3'(k + (k == 4 ? 3 : 0));
				case (k)
					1: begin
						it.pos_x = 16'sh7FFF; it.pos_y = 16'sh7FFF; it.pos_z = 16'sh7FFF;
						it.radius = '1; it.half_x = '1; it.half_y = '1; it.half_z = '1;
						it.axis_u = '1; it.axis_v = {3{16'h7FFF}}; it.axis_w = {3{16'h8000}};
					end
					2: begin
						it.pos_x = 16'sh8000; it.pos_y = 16'sh8000; it.pos_z = 16'sh8000;
						it.axis_u = {3{16'h8000}}; it.half_x = '1;
					end
					3: it = rand_item();
					default: ;
				endcase
				it.opcode = 2'(op);
				send(it);
			end
		end
		start <= 0;
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		directed();
		drain();
		for (int phase = 0; phase < 6; phase++) begin
			for (int p = 0; p < fct_pkg::REG_COUNT; p++)
				write_plane(p, rand_plane(phase == 1 ? 1 : phase == 2 ? 2 : phase == 3 ? 0 : 3));
			if (phase == 4) write_plane(fct_pkg::REG_COUNT + 1, '1);
			for (int n = 0; n < 225; n++) begin
				if (n == 100) begin
					start <= 0;
					drain();
				end
				send(rand_item());
				if (phase != 2) pause_random();
			end
			start <= 0;
			drain();
		end
		if (sb.mismatches == 0 && sb.pending.size() == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end
endmodule
